// ===== rtl/core/ffha_pkg.sv =====
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dp and first_fit_heap_allocator; no dependencies.
`default_nettype none
package ffha_pkg;

  localparam int ADDR_BITS    = 20;
  localparam int SIZE_BITS    = 21;
  localparam int CALC_BITS    = 23;
  localparam int MAX_BLOCKS   = 256;
  localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
  localparam int LINK_BITS    = IDX_BITS + 1;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 32;
  localparam int DATA_BITS    = 48;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESIZE  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
    logic [SIZE_BITS-1:0] req;
    logic                 free;
    logic [LINK_BITS-1:0] link;
  } entry_t;

  typedef enum logic [4:0] {
    CMD_NOP, CMD_LOAD, CMD_RES_NULL, CMD_RES_OOM, CMD_RES_OK0, CMD_RES_ADDR,
    CMD_WALK_INIT, CMD_WALK_RD, CMD_LOOK_NEXT, CMD_LOOK_HIT, CMD_ALLOC_NEXT,
    CMD_ALLOC_HIT, CMD_SCAN_INIT, CMD_SCAN_STEP, CMD_SPLIT_MK, CMD_TAKE,
    CMD_NEW, CMD_TAIL_RD, CMD_TAIL_WR, CMD_FREE_B, CMD_MERGE_RD, CMD_MERGE_DO,
    CMD_P_RD, CMD_WB_CAP, CMD_REQ_WR, CMD_S_TO_B, CMD_N_CAP, CMD_ABSORB,
    CMD_EXT_NEXT, CMD_EXT_TAIL, CMD_SAVE_CL, CMD_MOVED
  } cmd_e;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_AL_ENTRY, S_AL_RD, S_AL_CHK, S_AL_TAKE, S_AL_END,
    S_AL_SCAN, S_AL_FAIL, S_AL_NEW, S_AL_TRD, S_AL_TWR, S_RL_ENTRY, S_LK_RD,
    S_LK_CHK, S_RL_CHK, S_MG_RD, S_MG_DO, S_RL_P, S_RL_PCAP, S_RL_END,
    S_RZ_CHK, S_RZ_NCAP, S_RZ_NCHK, S_RZ_TL, S_RZ_SHR, S_RZ_S2B, S_SP_CHK,
    S_SP_SCAN, S_SP_MK, S_FINISH
  } state_e;

  typedef enum logic {SP_RET_ALLOC, SP_RET_SHRINK} sp_ret_e;
  typedef enum logic [1:0] {MG_RET_REL_B, MG_RET_REL_P, MG_RET_DONE} mg_ret_e;

  typedef struct packed {
    logic [1:0] op;
    logic size_zero;
    logic addr_zero;
    logic cur_none;
    logic look_match;
    logic fit;
    logic scan_hit;
    logic scan_end;
    logic split_small;
    logic tail_none;
    logic wb_free;
    logic p_none;
    logic nb_ok;
    logic comb_fit;
    logic n_is_tail;
    logic ext_next_ok;
    logic shrink_ok;
    logic tail_is_b;
    logic ext_tail_ok;
    logic grow_ok;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
// Sequencer for the heap allocator: walks, splits, merges, moves.
// Depends on ffha_pkg; drives ffha_dp through a command code.
`default_nettype none
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  ffha_pkg::dp_status_t st,
  output ffha_pkg::cmd_e      cmd,
  output logic                finish
);

  ffha_pkg::state_e  state, state_next;
  ffha_pkg::sp_ret_e sp_ret, sp_ret_next;
  ffha_pkg::mg_ret_e mg_ret, mg_ret_next;
  logic lk_res, lk_res_next;
  logic in_move, in_move_next;
  logic split_ok, split_ok_next;
  ffha_pkg::state_e  sp_back;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ffha_pkg::S_IDLE;
      sp_ret   <= ffha_pkg::SP_RET_ALLOC;
      mg_ret   <= ffha_pkg::MG_RET_DONE;
      lk_res   <= 1'b0;
      in_move  <= 1'b0;
      split_ok <= 1'b0;
    end else begin
      state    <= state_next;
      sp_ret   <= sp_ret_next;
      mg_ret   <= mg_ret_next;
      lk_res   <= lk_res_next;
      in_move  <= in_move_next;
      split_ok <= split_ok_next;
    end
  end

  assign s_tready = (state == ffha_pkg::S_IDLE);
  assign finish   = (state == ffha_pkg::S_FINISH) && st.out_free;
  assign sp_back  = (sp_ret == ffha_pkg::SP_RET_ALLOC) ? ffha_pkg::S_AL_TAKE
                                                       : ffha_pkg::S_RZ_SHR;

  always_comb begin
    state_next    = state;
    cmd           = ffha_pkg::CMD_NOP;
    sp_ret_next   = sp_ret;
    mg_ret_next   = mg_ret;
    lk_res_next   = lk_res;
    in_move_next  = in_move;
    split_ok_next = split_ok;
    unique case (state)
      ffha_pkg::S_IDLE: begin
        in_move_next = 1'b0;
        if (s_tvalid) begin
          cmd        = ffha_pkg::CMD_LOAD;
          state_next = ffha_pkg::S_DISPATCH;
        end
      end
      ffha_pkg::S_DISPATCH: begin
        priority if (st.op == ffha_pkg::OP_ALLOC) begin
          state_next = ffha_pkg::S_AL_ENTRY;
        end else if (st.op == ffha_pkg::OP_RELEASE) begin
          cmd        = ffha_pkg::CMD_RES_OK0;
          state_next = ffha_pkg::S_RL_ENTRY;
        end else if (st.op == ffha_pkg::OP_RESIZE) begin
          priority if (st.addr_zero) begin
            state_next = ffha_pkg::S_AL_ENTRY;
          end else if (st.size_zero) begin
            cmd        = ffha_pkg::CMD_RES_NULL;
            state_next = ffha_pkg::S_RL_ENTRY;
          end else begin
            cmd         = ffha_pkg::CMD_WALK_INIT;
            lk_res_next = 1'b1;
            state_next  = ffha_pkg::S_LK_RD;
          end
        end else begin
          cmd        = ffha_pkg::CMD_RES_NULL;
          state_next = ffha_pkg::S_FINISH;
        end
      end
      ffha_pkg::S_AL_ENTRY: begin
        if (st.size_zero) begin
          cmd        = ffha_pkg::CMD_RES_NULL;
          state_next = ffha_pkg::S_FINISH;
        end else begin
          cmd        = ffha_pkg::CMD_WALK_INIT;
          state_next = ffha_pkg::S_AL_RD;
        end
      end
      ffha_pkg::S_AL_RD: begin
        if (st.cur_none) begin
          cmd        = ffha_pkg::CMD_SCAN_INIT;
          state_next = ffha_pkg::S_AL_SCAN;
        end else begin
          cmd        = ffha_pkg::CMD_WALK_RD;
          state_next = ffha_pkg::S_AL_CHK;
        end
      end
      ffha_pkg::S_AL_CHK: begin
        if (st.fit) begin
          cmd         = ffha_pkg::CMD_ALLOC_HIT;
          sp_ret_next = ffha_pkg::SP_RET_ALLOC;
          state_next  = ffha_pkg::S_SP_CHK;
        end else begin
          cmd        = ffha_pkg::CMD_ALLOC_NEXT;
          state_next = ffha_pkg::S_AL_RD;
        end
      end
      ffha_pkg::S_AL_TAKE: begin
        cmd        = ffha_pkg::CMD_TAKE;
        state_next = ffha_pkg::S_AL_END;
      end
      ffha_pkg::S_AL_END: begin
        state_next = in_move ? ffha_pkg::S_RL_ENTRY : ffha_pkg::S_FINISH;
      end
      ffha_pkg::S_AL_SCAN: begin
        cmd = ffha_pkg::CMD_SCAN_STEP;
        priority if (st.scan_hit) begin
          state_next = st.grow_ok ? ffha_pkg::S_AL_NEW : ffha_pkg::S_AL_FAIL;
        end else if (st.scan_end) begin
          state_next = ffha_pkg::S_AL_FAIL;
        end else begin
          state_next = ffha_pkg::S_AL_SCAN;
        end
      end
      ffha_pkg::S_AL_FAIL: begin
        cmd        = ffha_pkg::CMD_RES_OOM;
        state_next = ffha_pkg::S_FINISH;
      end
      ffha_pkg::S_AL_NEW: begin
        cmd        = ffha_pkg::CMD_NEW;
        state_next = st.tail_none ? ffha_pkg::S_AL_END : ffha_pkg::S_AL_TRD;
      end
      ffha_pkg::S_AL_TRD: begin
        cmd        = ffha_pkg::CMD_TAIL_RD;
        state_next = ffha_pkg::S_AL_TWR;
      end
      ffha_pkg::S_AL_TWR: begin
        cmd        = ffha_pkg::CMD_TAIL_WR;
        state_next = ffha_pkg::S_AL_END;
      end
      ffha_pkg::S_RL_ENTRY: begin
        if (st.addr_zero) begin
          state_next = ffha_pkg::S_RL_END;
        end else begin
          cmd         = ffha_pkg::CMD_WALK_INIT;
          lk_res_next = 1'b0;
          state_next  = ffha_pkg::S_LK_RD;
        end
      end
      ffha_pkg::S_LK_RD: begin
        priority if (!st.cur_none) begin
          cmd        = ffha_pkg::CMD_WALK_RD;
          state_next = ffha_pkg::S_LK_CHK;
        end else if (lk_res) begin
          cmd        = ffha_pkg::CMD_RES_NULL;
          state_next = ffha_pkg::S_FINISH;
        end else begin
          state_next = ffha_pkg::S_RL_END;
        end
      end
      ffha_pkg::S_LK_CHK: begin
        if (st.look_match) begin
          cmd        = ffha_pkg::CMD_LOOK_HIT;
          state_next = lk_res ? ffha_pkg::S_RZ_CHK : ffha_pkg::S_RL_CHK;
        end else begin
          cmd        = ffha_pkg::CMD_LOOK_NEXT;
          state_next = ffha_pkg::S_LK_RD;
        end
      end
      ffha_pkg::S_RL_CHK: begin
        if (st.wb_free) begin
          state_next = ffha_pkg::S_RL_END;
        end else begin
          cmd         = ffha_pkg::CMD_FREE_B;
          mg_ret_next = ffha_pkg::MG_RET_REL_B;
          state_next  = ffha_pkg::S_MG_RD;
        end
      end
      ffha_pkg::S_MG_RD: begin
        // the previous block only takes in its neighbor when it is free itself
        if (mg_ret == ffha_pkg::MG_RET_REL_P && !st.wb_free) begin
          state_next = ffha_pkg::S_RL_END;
        end else begin
          cmd        = ffha_pkg::CMD_MERGE_RD;
          state_next = ffha_pkg::S_MG_DO;
        end
      end
      ffha_pkg::S_MG_DO: begin
        cmd = ffha_pkg::CMD_MERGE_DO;
        unique case (mg_ret)
          ffha_pkg::MG_RET_REL_B: state_next = ffha_pkg::S_RL_P;
          ffha_pkg::MG_RET_REL_P: state_next = ffha_pkg::S_RL_END;
          default:                state_next = ffha_pkg::S_FINISH;
        endcase
      end
      ffha_pkg::S_RL_P: begin
        if (st.p_none) begin
          state_next = ffha_pkg::S_RL_END;
        end else begin
          cmd        = ffha_pkg::CMD_P_RD;
          state_next = ffha_pkg::S_RL_PCAP;
        end
      end
      ffha_pkg::S_RL_PCAP: begin
        cmd         = ffha_pkg::CMD_WB_CAP;
        mg_ret_next = ffha_pkg::MG_RET_REL_P;
        state_next  = ffha_pkg::S_MG_RD;
      end
      ffha_pkg::S_RL_END: begin
        if (in_move) cmd = ffha_pkg::CMD_MOVED;
        state_next = ffha_pkg::S_FINISH;
      end
      ffha_pkg::S_RZ_CHK: begin
        priority if (st.wb_free) begin
          cmd        = ffha_pkg::CMD_RES_NULL;
          state_next = ffha_pkg::S_FINISH;
        end else if (st.shrink_ok) begin
          cmd         = ffha_pkg::CMD_RES_ADDR;
          sp_ret_next = ffha_pkg::SP_RET_SHRINK;
          state_next  = ffha_pkg::S_SP_CHK;
        end else begin
          cmd        = ffha_pkg::CMD_MERGE_RD;
          state_next = ffha_pkg::S_RZ_NCAP;
        end
      end
      ffha_pkg::S_RZ_NCAP: begin
        cmd        = ffha_pkg::CMD_N_CAP;
        state_next = ffha_pkg::S_RZ_NCHK;
      end
      ffha_pkg::S_RZ_NCHK: begin
        priority if (st.nb_ok && st.comb_fit) begin
          cmd         = ffha_pkg::CMD_ABSORB;
          sp_ret_next = ffha_pkg::SP_RET_SHRINK;
          state_next  = ffha_pkg::S_SP_CHK;
        end else if (st.nb_ok && st.n_is_tail && st.ext_next_ok) begin
          cmd        = ffha_pkg::CMD_EXT_NEXT;
          state_next = ffha_pkg::S_FINISH;
        end else begin
          state_next = ffha_pkg::S_RZ_TL;
        end
      end
      ffha_pkg::S_RZ_TL: begin
        if (st.tail_is_b && st.ext_tail_ok) begin
          cmd        = ffha_pkg::CMD_EXT_TAIL;
          state_next = ffha_pkg::S_FINISH;
        end else begin
          cmd          = ffha_pkg::CMD_SAVE_CL;
          in_move_next = 1'b1;
          state_next   = ffha_pkg::S_AL_ENTRY;
        end
      end
      ffha_pkg::S_RZ_SHR: begin
        cmd        = ffha_pkg::CMD_REQ_WR;
        state_next = split_ok ? ffha_pkg::S_RZ_S2B : ffha_pkg::S_FINISH;
      end
      ffha_pkg::S_RZ_S2B: begin
        cmd         = ffha_pkg::CMD_S_TO_B;
        mg_ret_next = ffha_pkg::MG_RET_DONE;
        state_next  = ffha_pkg::S_MG_RD;
      end
      ffha_pkg::S_SP_CHK: begin
        if (st.split_small) begin
          split_ok_next = 1'b0;
          state_next    = sp_back;
        end else begin
          cmd        = ffha_pkg::CMD_SCAN_INIT;
          state_next = ffha_pkg::S_SP_SCAN;
        end
      end
      ffha_pkg::S_SP_SCAN: begin
        cmd = ffha_pkg::CMD_SCAN_STEP;
        priority if (st.scan_hit) begin
          state_next = ffha_pkg::S_SP_MK;
        end else if (st.scan_end) begin
          split_ok_next = 1'b0;
          state_next    = sp_back;
        end else begin
          state_next = ffha_pkg::S_SP_SCAN;
        end
      end
      ffha_pkg::S_SP_MK: begin
        cmd           = ffha_pkg::CMD_SPLIT_MK;
        split_ok_next = 1'b1;
        state_next    = sp_back;
      end
      ffha_pkg::S_FINISH: begin
        if (st.out_free) state_next = ffha_pkg::S_IDLE;
      end
      default: state_next = ffha_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/ffha_dp.sv =====
// Datapath for the heap allocator: block table memory, list pointers,
// slot-use bits, heap top and result register. Depends on ffha_pkg.
`default_nettype none
module ffha_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  ffha_pkg::cmd_e               cmd,
  input  logic                         finish,
  input  logic [1:0]                   in_op,
  input  logic [ffha_pkg::SIZE_BITS-1:0] in_size,
  input  logic [ffha_pkg::ADDR_BITS-1:0] in_addr,
  input  logic                         cfg_wr_en,
  input  logic [ffha_pkg::SIZE_BITS-1:0] cfg_wr_data,
  input  logic                         m_tready,
  output logic                         m_tvalid,
  output logic [ffha_pkg::DATA_BITS-1:0] m_tdata,
  output ffha_pkg::dp_status_t         st
);

  localparam int CB = ffha_pkg::CALC_BITS;
  localparam int SB = ffha_pkg::SIZE_BITS;
  localparam int AB = ffha_pkg::ADDR_BITS;
  localparam int IB = ffha_pkg::IDX_BITS;
  localparam int LB = ffha_pkg::LINK_BITS;
  localparam logic [CB-1:0] HDR   = CB'(ffha_pkg::HEADER_BYTES);
  localparam logic [CB-1:0] AMSK  = CB'(ffha_pkg::ALIGN_BYTES - 1);
  localparam logic [CB-1:0] MINR  = CB'(ffha_pkg::HEADER_BYTES + ffha_pkg::ALIGN_BYTES);
  localparam logic [CB-1:0] CAP   = CB'(1) << AB;
  localparam logic [LB-1:0] NONE  = LB'(ffha_pkg::MAX_BLOCKS);
  localparam logic [IB-1:0] LASTI = IB'(ffha_pkg::MAX_BLOCKS - 1);

  ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::entry_t rdata, wb, ws, wn, wr_data;
  logic [IB-1:0] rd_idx, wr_idx;
  logic          wr_en;

  // control state
  logic [LB-1:0] head, tail;
  logic [SB-1:0] top, limit;
  logic [ffha_pkg::MAX_BLOCKS-1:0] in_use;

  // payload
  logic [1:0]    op_r;
  logic [SB-1:0] size_r, cl;
  logic [AB-1:0] addr_r;
  logic [CB-1:0] al;
  logic [IB-1:0] b, s, scan_i;
  logic [LB-1:0] p, cur;
  logic [AB-1:0] res_addr;
  logic [1:0]    res_status;
  logic          res_moved;
  logic [SB-1:0] res_copy;

  logic [CB-1:0] lim_eff, combined, merged, rem, al_in;
  logic          merge_ok;
  ffha_pkg::entry_t wb_m, ent_new;

  function automatic logic adj(input ffha_pkg::entry_t l, input ffha_pkg::entry_t r);
    return (CB'(l.start) + HDR + CB'(l.size)) == CB'(r.start);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    rdata <= mem[rd_idx];
  end

  assign al_in    = (CB'(in_size) + AMSK) & ~AMSK;
  assign lim_eff  = (CB'(limit) > CAP) ? CAP : CB'(limit);
  assign combined = CB'(wb.size) + HDR + CB'(wn.size);
  assign merged   = CB'(wb.size) + HDR + CB'(rdata.size);
  assign rem      = CB'(wb.size) - al;
  assign merge_ok = !wb.link[LB-1] && rdata.free && adj(wb, rdata);

  always_comb begin
    wb_m = wb;
    if (merge_ok) begin
      wb_m.size = merged[SB-1:0];
      wb_m.link = rdata.link;
    end
    ent_new.start = AB'(CB'(wb.start) + HDR + al);
    ent_new.size  = SB'(rem - HDR);
    ent_new.req   = '0;
    ent_new.free  = 1'b1;
    ent_new.link  = wb.link;
  end

  // status to the sequencer
  always_comb begin
    st.op          = op_r;
    st.size_zero   = (size_r == '0);
    st.addr_zero   = (addr_r == '0);
    st.cur_none    = cur[LB-1];
    st.look_match  = (CB'(rdata.start) + HDR) == CB'(addr_r);
    st.fit         = rdata.free && (CB'(rdata.size) >= al);
    st.scan_hit    = !in_use[scan_i];
    st.scan_end    = (scan_i == LASTI);
    st.split_small = rem < MINR;
    st.tail_none   = tail[LB-1];
    st.wb_free     = wb.free;
    st.p_none      = p[LB-1];
    st.nb_ok       = !wb.link[LB-1] && wn.free && adj(wb, wn);
    st.comb_fit    = combined >= al;
    st.n_is_tail   = (wb.link == tail);
    st.ext_next_ok = (CB'(top) + al) <= (lim_eff + combined);
    st.shrink_ok   = al <= CB'(wb.size);
    st.tail_is_b   = (tail == {1'b0, b});
    st.ext_tail_ok = (CB'(top) + al) <= (lim_eff + CB'(wb.size));
    st.grow_ok     = (CB'(top) + HDR + al) <= lim_eff;
    st.out_free    = !m_tvalid || m_tready;
  end

  // memory port selection
  always_comb begin
    rd_idx  = cur[IB-1:0];
    wr_en   = 1'b0;
    wr_idx  = b;
    wr_data = wb;
    unique case (cmd)
      ffha_pkg::CMD_MERGE_RD: rd_idx = wb.link[IB-1:0];
      ffha_pkg::CMD_P_RD:     rd_idx = p[IB-1:0];
      ffha_pkg::CMD_TAIL_RD:  rd_idx = tail[IB-1:0];
      default:                rd_idx = cur[IB-1:0];
    endcase
    unique case (cmd)
      ffha_pkg::CMD_TAKE: begin
        wr_en        = 1'b1;
        wr_data.free = 1'b0;
        wr_data.req  = size_r;
      end
      ffha_pkg::CMD_REQ_WR: begin
        wr_en       = 1'b1;
        wr_data.req = size_r;
      end
      ffha_pkg::CMD_MERGE_DO: begin
        wr_en   = 1'b1;
        wr_data = wb_m;
      end
      ffha_pkg::CMD_SPLIT_MK: begin
        wr_en   = 1'b1;
        wr_idx  = scan_i;
        wr_data = ent_new;
      end
      ffha_pkg::CMD_NEW: begin
        wr_en         = 1'b1;
        wr_idx        = scan_i;
        wr_data.start = top[AB-1:0];
        wr_data.size  = al[SB-1:0];
        wr_data.req   = size_r;
        wr_data.free  = 1'b0;
        wr_data.link  = NONE;
      end
      ffha_pkg::CMD_TAIL_WR: begin
        wr_en        = 1'b1;
        wr_idx       = tail[IB-1:0];
        wr_data      = rdata;
        wr_data.link = {1'b0, s};
      end
      ffha_pkg::CMD_EXT_NEXT: begin
        wr_en        = 1'b1;
        wr_data.size = al[SB-1:0];
        wr_data.link = wn.link;
        wr_data.req  = size_r;
      end
      ffha_pkg::CMD_EXT_TAIL: begin
        wr_en        = 1'b1;
        wr_data.size = al[SB-1:0];
        wr_data.req  = size_r;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= NONE;
      tail     <= NONE;
      top      <= '0;
      limit    <= SB'(CAP);
      in_use   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr_en) limit <= cfg_wr_data;
      if (finish && st.out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (cmd)
        ffha_pkg::CMD_MERGE_DO: begin
          if (merge_ok) begin
            in_use[wb.link[IB-1:0]] <= 1'b0;
            if (tail == wb.link) tail <= {1'b0, b};
          end
        end
        ffha_pkg::CMD_SPLIT_MK: begin
          in_use[scan_i] <= 1'b1;
          if (tail == {1'b0, b}) tail <= {1'b0, scan_i};
        end
        ffha_pkg::CMD_NEW: begin
          in_use[scan_i] <= 1'b1;
          top <= SB'(CB'(top) + HDR + al);
          if (tail[LB-1]) begin
            head <= {1'b0, scan_i};
            tail <= {1'b0, scan_i};
          end
        end
        ffha_pkg::CMD_TAIL_WR: tail <= {1'b0, s};
        ffha_pkg::CMD_ABSORB: begin
          in_use[wb.link[IB-1:0]] <= 1'b0;
          if (tail == wb.link) tail <= {1'b0, b};
        end
        ffha_pkg::CMD_EXT_NEXT: begin
          in_use[wb.link[IB-1:0]] <= 1'b0;
          tail <= {1'b0, b};
          top  <= SB'(CB'(top) + al - combined);
        end
        ffha_pkg::CMD_EXT_TAIL: top <= SB'(CB'(top) + al - CB'(wb.size));
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (finish && st.out_free) begin
      m_tdata <= {4'b0, res_copy, res_moved, res_status, res_addr};
    end
    unique case (cmd)
      ffha_pkg::CMD_LOAD: begin
        op_r       <= in_op;
        size_r     <= in_size;
        addr_r     <= in_addr;
        al         <= al_in;
        res_addr   <= '0;
        res_status <= ffha_pkg::ST_NULL;
        res_moved  <= 1'b0;
        res_copy   <= '0;
      end
      ffha_pkg::CMD_RES_NULL: begin
        res_addr   <= '0;
        res_status <= ffha_pkg::ST_NULL;
      end
      ffha_pkg::CMD_RES_OOM: begin
        res_addr   <= '0;
        res_status <= ffha_pkg::ST_OOM;
      end
      ffha_pkg::CMD_RES_OK0: begin
        res_addr   <= '0;
        res_status <= ffha_pkg::ST_OK;
      end
      ffha_pkg::CMD_RES_ADDR: begin
        res_addr   <= addr_r;
        res_status <= ffha_pkg::ST_OK;
      end
      ffha_pkg::CMD_WALK_INIT: begin
        cur <= head;
        p   <= NONE;
      end
      ffha_pkg::CMD_LOOK_NEXT: begin
        p   <= cur;
        cur <= rdata.link;
      end
      ffha_pkg::CMD_ALLOC_NEXT: cur <= rdata.link;
      ffha_pkg::CMD_LOOK_HIT, ffha_pkg::CMD_ALLOC_HIT: begin
        wb <= rdata;
        b  <= cur[IB-1:0];
      end
      ffha_pkg::CMD_SCAN_INIT: scan_i <= '0;
      ffha_pkg::CMD_SCAN_STEP: begin
        if (in_use[scan_i] && scan_i != LASTI) scan_i <= scan_i + 1'b1;
      end
      ffha_pkg::CMD_SPLIT_MK: begin
        ws      <= ent_new;
        s       <= scan_i;
        wb.size <= al[SB-1:0];
        wb.link <= {1'b0, scan_i};
      end
      ffha_pkg::CMD_TAKE: begin
        wb.free    <= 1'b0;
        wb.req     <= size_r;
        res_addr   <= AB'(CB'(wb.start) + HDR);
        res_status <= ffha_pkg::ST_OK;
      end
      ffha_pkg::CMD_NEW: begin
        s          <= scan_i;
        res_addr   <= AB'(CB'(top) + HDR);
        res_status <= ffha_pkg::ST_OK;
      end
      ffha_pkg::CMD_FREE_B: wb.free <= 1'b1;
      ffha_pkg::CMD_MERGE_DO: wb <= wb_m;
      ffha_pkg::CMD_P_RD: b <= p[IB-1:0];
      ffha_pkg::CMD_WB_CAP: wb <= rdata;
      ffha_pkg::CMD_REQ_WR: wb.req <= size_r;
      ffha_pkg::CMD_S_TO_B: begin
        wb <= ws;
        b  <= s;
      end
      ffha_pkg::CMD_N_CAP: wn <= rdata;
      ffha_pkg::CMD_ABSORB: begin
        wb.size    <= combined[SB-1:0];
        wb.link    <= wn.link;
        res_addr   <= addr_r;
        res_status <= ffha_pkg::ST_OK;
      end
      ffha_pkg::CMD_EXT_NEXT, ffha_pkg::CMD_EXT_TAIL: begin
        res_addr   <= addr_r;
        res_status <= ffha_pkg::ST_OK;
      end
      ffha_pkg::CMD_SAVE_CL: cl <= (wb.req < size_r) ? wb.req : size_r;
      ffha_pkg::CMD_MOVED: begin
        res_moved <= 1'b1;
        res_copy  <= cl;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// First-fit heap allocator: top level joining the sequencer and datapath.
// The time from accept to response grows with each list node walked and each occupied
//   slot skipped by the slot-use scan of the 256 slots; a move chains lookup, allocate
//   and release walks.
// Throughput: one transaction in flight; the next is taken the cycle after the
//   response is registered. Reset (rst, synchronous): empty list, heap top zero,
//   limit 1048576, no response pending.
`default_nettype none
module first_fit_heap_allocator (
  input  logic        clk,
  input  logic        rst,
  // configuration: heap_limit
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [20:0] size, [40:21] address, zero fill
  input  logic [1:0]  s_tuser,   // [1:0] operation
  // response stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // [19:0] result_address, [21:20] status,
                                 // [22] moved, [43:23] copy_length, zero fill
);

  ffha_pkg::cmd_e       cmd;
  ffha_pkg::dp_status_t st;
  logic                 finish;

  // The sequencer sits in its finish state until the response register frees.
  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd),
    .finish   (finish)
  );

  ffha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .finish      (finish),
    .in_op       (s_tuser),
    .in_size     (s_tdata[20:0]),
    .in_addr     (s_tdata[40:21]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tready    (m_tready),
    .m_tvalid    (m_tvalid),
    .m_tdata     (m_tdata),
    .st          (st)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while a transaction is in progress");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[21:20] != 2'd3))
    else $error("undefined status code on response");

  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[22]) |-> (m_tdata[21:20] == ffha_pkg::ST_OK))
    else $error("move reported without ok status");
`endif

endmodule
`default_nettype wire
